/* rtl/core/ctalu_pkg.sv */
package ctalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_AND = 4'd5,
		OP_OR  = 4'd6,
		OP_XOR = 4'd7,
		OP_SHL = 4'd8,
		OP_SHR = 4'd9,
		OP_EQ  = 4'd10,
		OP_NE  = 4'd11,
		OP_LT  = 4'd12,
		OP_LE  = 4'd13,
		OP_GT  = 4'd14,
		OP_GE  = 4'd15
	} op_t;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} st_t;

	// Classified item passed from front to back
	typedef struct packed {
		op_t         op;
		logic [1:0]  wc;
		logic        sgn;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] ma;
		logic [63:0] mb;
		logic        na;
		logic        nb;
		logic        cnt_bad;
		logic [5:0]  cnt;
		logic        div_bad;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
		logic [1:0]  wc;
		logic        sgn;
	} result_t;

	function automatic logic [63:0] width_mask(input logic [1:0] wc);
		logic [63:0] m;
		case (wc)
			WC_8:    m = 64'h0000_0000_0000_00FF;
			WC_16:   m = 64'h0000_0000_0000_FFFF;
			WC_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] sign_bit(input logic [1:0] wc);
		logic [63:0] s;
		case (wc)
			WC_8:    s = 64'h0000_0000_0000_0080;
			WC_16:   s = 64'h0000_0000_0000_8000;
			WC_32:   s = 64'h0000_0000_8000_0000;
			default: s = 64'h8000_0000_0000_0000;
		endcase
		return s;
	endfunction

	// A failed operation reports all zeros
	function automatic result_t make_result(input logic ok, input logic [63:0] value,
			input logic [1:0] wc, input logic sgn);
		result_t r;
		r.ok    = ok;
		r.value = ok ? value : 64'd0;
		r.wc    = ok ? wc : WC_8;
		r.sgn   = ok ? sgn : 1'b0;
		return r;
	endfunction

endpackage

/* rtl/core/ctalu_if.sv */
interface ctalu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [1:0]  width_code;
	logic        is_signed;
	logic [63:0] left_value;
	logic [63:0] right_value;
	logic [1:0]  right_width_code;
	logic        right_signed;

	modport source (output valid, req_type, width_code, is_signed, left_value, right_value,
		right_width_code, right_signed, input ready);
	modport sink (input valid, req_type, width_code, is_signed, left_value, right_value,
		right_width_code, right_signed, output ready);
endinterface

interface ctalu_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] result_value;
	logic [1:0]  result_width_code;
	logic        result_signed;

	modport source (output valid, ok, result_value, result_width_code, result_signed,
		input ready);
	modport sink (input valid, ok, result_value, result_width_code, result_signed,
		output ready);
endinterface

/* rtl/core/ctalu_front.sv */
module ctalu_front
	import ctalu_pkg::*;
(
	ctalu_req_if.sink req,
	input  logic      full,
	output logic      push,
	output item_t     item
);

	logic [63:0] mask;
	logic [63:0] sb;
	logic [63:0] a;
	logic [63:0] b;
	logic [63:0] rmask;
	logic [63:0] rsb;
	logic [63:0] cnt;
	logic [6:0]  bits;
	logic        cnt_neg;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		mask    = width_mask(req.width_code);
		sb      = sign_bit(req.width_code);
		a       = req.left_value & mask;
		b       = req.right_value & mask;
		rmask   = width_mask(req.right_width_code);
		rsb     = sign_bit(req.right_width_code);
		cnt     = req.right_value & rmask;
		cnt_neg = req.right_signed && ((cnt & rsb) != 64'd0);
		bits    = 7'd8 << req.width_code;

		item.op      = op_t'(req.req_type);
		item.wc      = req.width_code;
		item.sgn     = req.is_signed;
		item.a       = a;
		item.b       = b;
		// sign flags only matter for signed work
		item.na      = req.is_signed && ((a & sb) != 64'd0);
		item.nb      = req.is_signed && ((b & sb) != 64'd0);
		item.ma      = item.na ? ((~a + 64'd1) & mask) : a;
		item.mb      = item.nb ? ((~b + 64'd1) & mask) : b;
		item.cnt_bad = cnt_neg || (cnt >= {57'd0, bits});
		item.cnt     = cnt[5:0];
		item.div_bad = (b == 64'd0) || (req.is_signed && a == sb && b == mask);
	end

endmodule

/* rtl/core/ctalu_fifo.sv */
module ctalu_fifo
	import ctalu_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t dout
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/ctalu_back.sv */
module ctalu_back
	import ctalu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  item_t     head,
	output logic      pop,
	ctalu_rsp_if.source rsp
);

	st_t         state_q, state_d;
	item_t       cur_q;
	logic [2:0]  step_q;
	logic [63:0] pp_q;
	logic [1:0]  pp_sh_q;
	logic        pp_v_q;
	logic [127:0] acc_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  dcnt_q;
	result_t     out_q, out_d;
	logic        out_v_q;
	logic        load_out;
	logic        out_free;
	logic        is_multi;

	// combinational datapath on the queue head
	logic [63:0] mask, sb, sum, diff, x, y, shl_v, shr_v, val;
	logic        rn, ok, cmp;
	result_t     simple_res;

	// multi-cycle finishing
	logic [63:0] cmask, csb, limit, plo, qv, rv;
	logic        neg, ovf;
	result_t     mul_res, div_res;

	logic [31:0]  mul_a, mul_b;
	logic [64:0]  trial;
	logic [64:0]  trial_sub;
	logic         trial_ge;

	assign out_free = !out_v_q || rsp.ready;
	assign is_multi = (head.op == OP_MUL) ||
		((head.op == OP_DIV || head.op == OP_MOD) && !head.div_bad);

	always_comb begin
		mask  = width_mask(head.wc);
		sb    = sign_bit(head.wc);
		sum   = (head.a + head.b) & mask;
		diff  = (head.a - head.b) & mask;
		x     = head.sgn ? (head.a ^ sb) : head.a;
		y     = head.sgn ? (head.b ^ sb) : head.b;
		shl_v = (head.a << head.cnt) & mask;
		shr_v = head.a >> head.cnt;
		if (head.na)
			shr_v = shr_v | (mask ^ (mask >> head.cnt));
		shr_v = shr_v & mask;
		rn    = 1'b0;
		ok    = 1'b1;
		val   = 64'd0;
		cmp   = 1'b0;
		case (head.op)
			OP_ADD: begin
				val = sum;
				rn  = (sum & sb) != 64'd0;
				ok  = !(head.sgn && head.na == head.nb && rn != head.na);
			end
			OP_SUB: begin
				val = diff;
				rn  = (diff & sb) != 64'd0;
				ok  = !(head.sgn && head.na != head.nb && rn != head.na);
			end
			OP_AND: val = head.a & head.b;
			OP_OR:  val = head.a | head.b;
			OP_XOR: val = head.a ^ head.b;
			OP_SHL: begin
				val = shl_v;
				ok  = !head.cnt_bad &&
					!(head.sgn && (head.na || head.a > (INT64_MAX >> head.cnt)));
			end
			OP_SHR: begin
				val = shr_v;
				ok  = !head.cnt_bad;
			end
			OP_EQ: cmp = (x == y);
			OP_NE: cmp = (x != y);
			OP_LT: cmp = (x < y);
			OP_LE: cmp = (x <= y);
			OP_GT: cmp = (x > y);
			OP_GE: cmp = (x >= y);
			default: ok = 1'b0; // div or mod with a bad divisor
		endcase
		if (head.op inside {OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE})
			simple_res = make_result(1'b1, {63'd0, cmp}, WC_8, 1'b0);
		else
			simple_res = make_result(ok, val, head.wc, head.sgn);
	end

	always_comb begin
		cmask   = width_mask(cur_q.wc);
		csb     = sign_bit(cur_q.wc);
		neg     = cur_q.na ^ cur_q.nb;
		limit   = neg ? csb : (csb - 64'd1);
		plo     = acc_q[63:0];
		ovf     = cur_q.sgn && ((acc_q[127:64] != 64'd0) || plo > limit);
		mul_res = make_result(!ovf, (neg ? (64'd0 - plo) : plo) & cmask, cur_q.wc, cur_q.sgn);
		qv      = (neg ? (64'd0 - quo_q) : quo_q) & cmask;
		rv      = (cur_q.na ? (64'd0 - rem_q) : rem_q) & cmask;
		div_res = make_result(1'b1, (cur_q.op == OP_DIV) ? qv : rv, cur_q.wc, cur_q.sgn);

		mul_a     = step_q[1] ? cur_q.ma[63:32] : cur_q.ma[31:0];
		mul_b     = step_q[0] ? cur_q.mb[63:32] : cur_q.mb[31:0];
		trial     = {rem_q, quo_q[63]};
		trial_ge  = trial >= {1'b0, cur_q.mb};
		trial_sub = trial - {1'b0, cur_q.mb};
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		out_d    = simple_res;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (is_multi) begin
						pop     = 1'b1;
						state_d = (head.op == OP_MUL) ? ST_MUL : ST_DIV;
					end else if (out_free) begin
						pop      = 1'b1;
						load_out = 1'b1;
					end
				end
			end
			ST_MUL: begin
				if (step_q == 3'd5 && out_free) begin
					load_out = 1'b1;
					out_d    = mul_res;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (dcnt_q[6] && out_free) begin
					load_out = 1'b1;
					out_d    = div_res;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= out_d;
		if (pop && is_multi) begin
			cur_q  <= head;
			step_q <= 3'd0;
			pp_v_q <= 1'b0;
			acc_q  <= 128'd0;
			quo_q  <= head.ma;
			rem_q  <= 64'd0;
			dcnt_q <= 7'd0;
		end else if (state_q == ST_MUL && step_q != 3'd5) begin
			// one 32x32 partial product per cycle, registered in pp_q and then summed into acc_q
			if (!step_q[2])
				pp_q <= mul_a * mul_b;
			pp_sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
			pp_v_q  <= !step_q[2];
			if (pp_v_q)
				acc_q <= acc_q + ({64'd0, pp_q} << {pp_sh_q, 5'd0});
			step_q <= step_q + 3'd1;
		end else if (state_q == ST_DIV && !dcnt_q[6]) begin
			rem_q  <= trial_ge ? trial_sub[63:0] : trial[63:0];
			quo_q  <= {quo_q[62:0], trial_ge};
			dcnt_q <= dcnt_q + 7'd1;
		end
	end

	assign rsp.valid             = out_v_q;
	assign rsp.ok                = out_q.ok;
	assign rsp.result_value      = out_q.value;
	assign rsp.result_width_code = out_q.wc;
	assign rsp.result_signed     = out_q.sgn;

endmodule

/* rtl/core/checked_typed_integer_alu.sv */
// Channel  Dir  Fields
// req      in   req_type, width_code, is_signed, left_value, right_value,
//               right_width_code, right_signed
// rsp      out  ok, result_value, result_width_code, result_signed
//
// The front classifies an item in the cycle it is taken and queues it; req
// accepts one item per cycle while the queue has room.
// Add, sub, logic, shifts and compares are worked on the head and then
// registered when the output is free; mul and good-divisor div and mod go
// to the back sequencer (mul: four 32x32 partial products, one multiplier;
// div/mod: one quotient bit per cycle); later items wait in the queue.
// Reset clears the queue, the back sequencer and the output valid.
// A stalled rsp holds its item; the queue keeps filling until it is full.
module checked_typed_integer_alu
	import ctalu_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input logic          clk,
	input logic          arst_n,
	ctalu_req_if.sink    req,
	ctalu_rsp_if.source  rsp
);

	item_t front_item;
	item_t head_item;
	logic  push;
	logic  full;
	logic  pop;
	logic  q_valid;

	ctalu_front u_front (
		.req  (req),
		.full (full),
		.push (push),
		.item (front_item)
	);

	ctalu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (full),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (head_item)
	);

	ctalu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head_item),
		.pop     (pop),
		.rsp     (rsp)
	);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ok |-> rsp.result_value == 64'd0 &&
			rsp.result_width_code == WC_8 && !rsp.result_signed)
		else $error("failed item carries nonzero fields");

	a_mask_8: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_width_code == WC_8 |-> rsp.result_value[63:8] == 56'd0)
		else $error("byte result not masked");

	a_mask_32: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_width_code == WC_32 |-> rsp.result_value[63:32] == 32'd0)
		else $error("word result not masked");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule
